>>> hdl/path_curvature_estimator_defines.svh
// Assertion macros for the path curvature estimator checker.
// Depends on a clk_i and rst_ni in the scope of use.
`ifndef PATH_CURVATURE_ESTIMATOR_DEFINES_SVH
`define PATH_CURVATURE_ESTIMATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PCE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PCE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/pce_pkg.sv
// Shared widths and helpers of the path curvature estimator.
// No dependencies.
package pce_pkg;

  localparam int CoordW = 32;
  localparam int CurvW  = 32;
  localparam int Frac   = 30;

  // Magnitude of a 33-bit difference of two coordinates.
  function automatic logic [31:0] mag33(logic signed [32:0] v);
    logic signed [32:0] n;
    n = -v;
    return v[32] ? n[31:0] : v[31:0];
  endfunction

endpackage

>>> hdl/pce_if.sv
// Valid/ready channel interfaces for path points and curvature results.
// Depends on pce_pkg.
interface pce_point_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pce_pkg::CoordW-1:0]    point_x;
  logic signed [pce_pkg::CoordW-1:0]    point_y;
  logic                                 path_end;

  modport source (output valid, point_x, point_y, path_end, input ready);
  modport sink   (input valid, point_x, point_y, path_end, output ready);
endinterface

interface pce_curv_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pce_pkg::CurvW-1:0]     curvature;
  logic                                 final_result;

  modport source (output valid, curvature, final_result, input ready);
  modport sink   (input valid, curvature, final_result, output ready);
endinterface

>>> hdl/path_curvature_estimator.sv
// Path curvature estimator: three-point discrete curvature of a streamed path.
// Depends on pce_pkg and the channel interfaces in pce_if.sv.
//
// Usage: path points enter on point_i (x, y in signed Q16.16, path_end on the
// last point); curvature results leave on curv_o (Q16.16, saturated), with
// final_result on the result of the path's last point. A request is taken
// when valid and ready are high at a rising edge.
// The first two points of a path are only stored. Every later point
// starts a curvature computation: one shared subtract unit runs the
// square roots (one root bit per cycle) and the divisions (one quotient
// bit per cycle, eight of them), and one 33x33 multiplier with a
// registered product does the squares, cross products and the velocity
// product. point_i.ready stays low during the computation and while results
// are handed out. The first window gives two results, a path end one more;
// a path of one or two points gives zeros.
// The output register lets a new point be taken while a result still waits.
// When curv_o stalls, the result holds and the block waits before the next one.
// Reset (rst_ni low, asynchronous) empties the point window and the output.
module path_curvature_estimator (
  input  logic          clk_i,
  input  logic          rst_ni,
  pce_point_if.sink     point_i,
  pce_curv_if.source    curv_o
);

  localparam logic [4:0] StIdle = 5'd0;
  localparam logic [4:0] StC1a  = 5'd1;
  localparam logic [4:0] StC1b  = 5'd2;
  localparam logic [4:0] StC1c  = 5'd3;
  localparam logic [4:0] StC1d  = 5'd4;
  localparam logic [4:0] StC2a  = 5'd5;
  localparam logic [4:0] StC2b  = 5'd6;
  localparam logic [4:0] StC2c  = 5'd7;
  localparam logic [4:0] StC2d  = 5'd8;
  localparam logic [4:0] StDxp  = 5'd9;
  localparam logic [4:0] StDyp  = 5'd10;
  localparam logic [4:0] StDux1 = 5'd11;
  localparam logic [4:0] StDux2 = 5'd12;
  localparam logic [4:0] StDuy1 = 5'd13;
  localparam logic [4:0] StDuy2 = 5'd14;
  localparam logic [4:0] StCrs1 = 5'd15;
  localparam logic [4:0] StCrs2 = 5'd16;
  localparam logic [4:0] StCrs3 = 5'd17;
  localparam logic [4:0] StCrs4 = 5'd18;
  localparam logic [4:0] StVel1 = 5'd19;
  localparam logic [4:0] StVel2 = 5'd20;
  localparam logic [4:0] StVel3 = 5'd21;
  localparam logic [4:0] StVmul = 5'd22;
  localparam logic [4:0] StDfin = 5'd23;
  localparam logic [4:0] StKout = 5'd24;
  localparam logic [4:0] StDiv  = 5'd25;
  localparam logic [4:0] StSqrt = 5'd26;
  localparam logic [4:0] StEmit = 5'd27;

  localparam logic [6:0] DivSteps  = 7'd63;
  localparam logic [6:0] SqrtSteps = 7'd32;

  logic [4:0]          state_q, ret_q;
  logic [1:0]          ps_q;
  logic signed [31:0]  wx0_q, wy0_q, wx1_q, wy1_q, cx_q, cy_q;
  logic                end_q;
  logic [33:0]         ds1_q, ds2_q;
  logic [34:0]         s_q;
  logic signed [31:0]  xp_q, yp_q, tmp_q, dux_q, duy_q;
  logic signed [65:0]  acc_q, mul_p_q;
  logic                neg_q;
  logic [47:0]         t_q;
  logic [30:0]         v2_q;
  logic [65:0]         work_q;
  logic [36:0]         rem_q;
  logic [33:0]         root_q;
  logic [34:0]         dvs_q;
  logic                div_neg_q;
  logic [6:0]          iter_q;
  logic [31:0]         k_q;
  logic [1:0]          emit_cnt_q;
  logic                emit_fin_q;
  logic                out_valid_q, out_fin_q;
  logic [31:0]         out_k_q;

  logic signed [32:0]  dx1, dy1, dx2, dy2, ddx, ddy;
  logic signed [32:0]  mul_a, mul_b;
  logic signed [65:0]  sumsq, cdiff;
  logic [65:0]         cmag;
  logic [36:0]         sub_a, sub_b;
  logic [37:0]         sub_r;
  logic                sub_fit;
  logic signed [31:0]  qs, qpos;
  logic [33:0]         ds_new;
  logic                launch_div, launch_sqrt;
  logic [63:0]         div_dvd;
  logic [34:0]         div_dvs;
  logic                div_neg;
  logic [65:0]         rad;
  logic [4:0]          launch_ret;
  logic [63:0]         qfin;
  logic [31:0]         k_sat;
  logic                accept;

  assign accept = point_i.valid && point_i.ready;
  assign point_i.ready = (state_q == StIdle);
  assign curv_o.valid = out_valid_q;
  assign curv_o.curvature = out_k_q;
  assign curv_o.final_result = out_fin_q;

  assign dx1 = {wx1_q[31], wx1_q} - {wx0_q[31], wx0_q};
  assign dy1 = {wy1_q[31], wy1_q} - {wy0_q[31], wy0_q};
  assign dx2 = {cx_q[31], cx_q} - {wx1_q[31], wx1_q};
  assign dy2 = {cy_q[31], cy_q} - {wy1_q[31], wy1_q};
  assign ddx = {cx_q[31], cx_q} - {wx0_q[31], wx0_q};
  assign ddy = {cy_q[31], cy_q} - {wy0_q[31], wy0_q};

  assign sumsq = acc_q + mul_p_q;
  assign cdiff = acc_q - mul_p_q;
  assign cmag  = cdiff[65] ? 66'(-cdiff) : cdiff;
  assign ds_new = root_q + 34'd1;

  assign qpos = signed'(work_q[31:0]);
  assign qs   = div_neg_q ? -qpos : qpos;

  // Shared unit: one restoring step of the divider or of the square root.
  assign sub_a = (state_q == StSqrt) ? {rem_q[34:0], work_q[65:64]}
                                     : {rem_q[35:0], work_q[63]};
  assign sub_b = (state_q == StSqrt) ? {1'b0, root_q, 2'b01} : {2'b00, dvs_q};
  assign sub_r = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_fit = !sub_r[37];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StC1a: begin
        mul_a = {1'b0, pce_pkg::mag33(dx1)};
        mul_b = {1'b0, pce_pkg::mag33(dx1)};
      end
      StC1b: begin
        mul_a = {1'b0, pce_pkg::mag33(dy1)};
        mul_b = {1'b0, pce_pkg::mag33(dy1)};
      end
      StC2a: begin
        mul_a = {1'b0, pce_pkg::mag33(dx2)};
        mul_b = {1'b0, pce_pkg::mag33(dx2)};
      end
      StC2b: begin
        mul_a = {1'b0, pce_pkg::mag33(dy2)};
        mul_b = {1'b0, pce_pkg::mag33(dy2)};
      end
      StCrs2: begin
        mul_a = {xp_q[31], xp_q};
        mul_b = {duy_q[31], duy_q};
      end
      StCrs3: begin
        mul_a = {yp_q[31], yp_q};
        mul_b = {dux_q[31], dux_q};
      end
      StVel1: begin
        mul_a = {xp_q[31], xp_q};
        mul_b = {xp_q[31], xp_q};
      end
      StVel2: begin
        mul_a = {yp_q[31], yp_q};
        mul_b = {yp_q[31], yp_q};
      end
      StVmul: begin
        mul_a = {2'b00, v2_q};
        mul_b = {2'b00, root_q[30:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Operands of the next divide or square root request.
  always_comb begin
    launch_div  = 1'b0;
    launch_sqrt = 1'b0;
    div_dvd     = '0;
    div_dvs     = '0;
    div_neg     = 1'b0;
    rad         = '0;
    launch_ret  = StIdle;
    case (state_q)
      StC1c: begin
        launch_sqrt = 1'b1;
        rad         = sumsq;
        launch_ret  = StC1d;
      end
      StC2c: begin
        launch_sqrt = 1'b1;
        rad         = sumsq;
        launch_ret  = StC2d;
      end
      StDxp: begin
        launch_div = 1'b1;
        div_dvd    = {2'b00, pce_pkg::mag33(ddx), 30'd0};
        div_dvs    = s_q;
        div_neg    = ddx[32];
        launch_ret = StDyp;
      end
      StDyp: begin
        launch_div = 1'b1;
        div_dvd    = {2'b00, pce_pkg::mag33(ddy), 30'd0};
        div_dvs    = s_q;
        div_neg    = ddy[32];
        launch_ret = StDux1;
      end
      StDux1: begin
        launch_div = 1'b1;
        div_dvd    = {2'b00, pce_pkg::mag33(dx1), 30'd0};
        div_dvs    = {1'b0, ds1_q};
        div_neg    = dx1[32];
        launch_ret = StDux2;
      end
      StDux2: begin
        launch_div = 1'b1;
        div_dvd    = {2'b00, pce_pkg::mag33(dx2), 30'd0};
        div_dvs    = {1'b0, ds2_q};
        div_neg    = dx2[32];
        launch_ret = StDuy1;
      end
      StDuy1: begin
        launch_div = 1'b1;
        div_dvd    = {2'b00, pce_pkg::mag33(dy1), 30'd0};
        div_dvs    = {1'b0, ds1_q};
        div_neg    = dy1[32];
        launch_ret = StDuy2;
      end
      StDuy2: begin
        launch_div = 1'b1;
        div_dvd    = {2'b00, pce_pkg::mag33(dy2), 30'd0};
        div_dvs    = {1'b0, ds2_q};
        div_neg    = dy2[32];
        launch_ret = StCrs1;
      end
      StCrs4: begin
        launch_div = 1'b1;
        div_dvd    = {15'd0, cmag[61:30], 17'd0};
        div_dvs    = s_q;
        launch_ret = StVel1;
      end
      StVel3: begin
        launch_sqrt = 1'b1;
        rad         = {5'd0, sumsq[60:30], 30'd0};
        launch_ret  = StVmul;
      end
      StDfin: begin
        launch_div = 1'b1;
        div_dvd    = {t_q, 16'd0};
        div_dvs    = {1'b0, mul_p_q[63:30]} + 35'd1;
        launch_ret = StKout;
      end
      default: begin
        launch_div = 1'b0;
      end
    endcase
  end

  // Saturate the final quotient to signed Q16.16.
  assign qfin = work_q[63:0];
  always_comb begin
    if (!neg_q) begin
      k_sat = (qfin > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : qfin[31:0];
    end else begin
      k_sat = (qfin > 64'h8000_0000) ? 32'h8000_0000 : 32'(-qfin[31:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ret_q       <= StIdle;
      ps_q        <= 2'd0;
      wx0_q       <= '0;
      wy0_q       <= '0;
      wx1_q       <= '0;
      wy1_q       <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      end_q       <= 1'b0;
      ds1_q       <= '0;
      ds2_q       <= '0;
      s_q         <= '0;
      xp_q        <= '0;
      yp_q        <= '0;
      tmp_q       <= '0;
      dux_q       <= '0;
      duy_q       <= '0;
      acc_q       <= '0;
      mul_p_q     <= '0;
      neg_q       <= 1'b0;
      t_q         <= '0;
      v2_q        <= '0;
      work_q      <= '0;
      rem_q       <= '0;
      root_q      <= '0;
      dvs_q       <= '0;
      div_neg_q   <= 1'b0;
      iter_q      <= '0;
      k_q         <= '0;
      emit_cnt_q  <= '0;
      emit_fin_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_fin_q   <= 1'b0;
      out_k_q     <= '0;
    end else begin
      mul_p_q <= mul_a * mul_b;
      if (out_valid_q && curv_o.ready && (state_q != StEmit)) begin
        out_valid_q <= 1'b0;
      end
      if (launch_div) begin
        work_q    <= {2'b00, div_dvd};
        dvs_q     <= div_dvs;
        div_neg_q <= div_neg;
        rem_q     <= '0;
        iter_q    <= DivSteps;
        ret_q     <= launch_ret;
      end
      if (launch_sqrt) begin
        work_q <= rad;
        rem_q  <= '0;
        root_q <= '0;
        iter_q <= SqrtSteps;
        ret_q  <= launch_ret;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            cx_q  <= point_i.point_x;
            cy_q  <= point_i.point_y;
            end_q <= point_i.path_end;
            case (ps_q)
              2'd0, 2'd1: begin
                if (point_i.path_end) begin
                  k_q        <= '0;
                  emit_cnt_q <= (ps_q == 2'd0) ? 2'd1 : 2'd2;
                  emit_fin_q <= 1'b1;
                  ps_q       <= 2'd0;
                  wx0_q      <= '0;
                  wy0_q      <= '0;
                  wx1_q      <= '0;
                  wy1_q      <= '0;
                  state_q    <= StEmit;
                end else begin
                  wx0_q <= wx1_q;
                  wy0_q <= wy1_q;
                  wx1_q <= point_i.point_x;
                  wy1_q <= point_i.point_y;
                  ps_q  <= ps_q + 2'd1;
                end
              end
              default: begin
                state_q <= StC1a;
              end
            endcase
          end
        end
        StC1a: state_q <= StC1b;
        StC1b: begin
          acc_q   <= mul_p_q;
          state_q <= StC1c;
        end
        StC1d: begin
          ds1_q   <= ds_new;
          state_q <= StC2a;
        end
        StC2a: state_q <= StC2b;
        StC2b: begin
          acc_q   <= mul_p_q;
          state_q <= StC2c;
        end
        StC2d: begin
          ds2_q   <= ds_new;
          s_q     <= {1'b0, ds1_q} + {1'b0, ds_new};
          state_q <= StDxp;
        end
        StDyp:  xp_q <= qs;
        StDux1: yp_q <= qs;
        StDux2: tmp_q <= qs;
        StDuy1: dux_q <= qs - tmp_q;
        StDuy2: tmp_q <= qs;
        StCrs1: begin
          duy_q   <= qs - tmp_q;
          state_q <= StCrs2;
        end
        StCrs2: state_q <= StCrs3;
        StCrs3: begin
          acc_q   <= mul_p_q;
          state_q <= StCrs4;
        end
        StCrs4: neg_q <= cdiff[65];
        StVel1: begin
          t_q     <= work_q[47:0];
          state_q <= StVel2;
        end
        StVel2: begin
          acc_q   <= mul_p_q;
          state_q <= StVel3;
        end
        StVel3: v2_q <= sumsq[60:30];
        StVmul: state_q <= StDfin;
        StKout: begin
          k_q        <= k_sat;
          emit_cnt_q <= ((ps_q == 2'd2) ? 2'd2 : 2'd1) + {1'b0, end_q};
          emit_fin_q <= end_q;
          // drop the window at path end, else advance it
          if (end_q) begin
            ps_q  <= 2'd0;
            wx0_q <= '0;
            wy0_q <= '0;
            wx1_q <= '0;
            wy1_q <= '0;
          end else begin
            ps_q  <= 2'd3;
            wx0_q <= wx1_q;
            wy0_q <= wy1_q;
            wx1_q <= cx_q;
            wy1_q <= cy_q;
          end
          state_q <= StEmit;
        end
        StDiv: begin
          if (sub_fit) begin
            rem_q <= sub_r[36:0];
          end else begin
            rem_q <= sub_a;
          end
          work_q <= {work_q[64:0], sub_fit};
          iter_q <= iter_q - 7'd1;
          if (iter_q == '0) begin
            state_q <= ret_q;
          end
        end
        StSqrt: begin
          if (sub_fit) begin
            rem_q <= sub_r[36:0];
          end else begin
            rem_q <= sub_a;
          end
          root_q <= {root_q[32:0], sub_fit};
          work_q <= {work_q[63:0], 2'b00};
          iter_q <= iter_q - 7'd1;
          if (iter_q == '0) begin
            state_q <= ret_q;
          end
        end
        StEmit: begin
          if (!out_valid_q || curv_o.ready) begin
            out_valid_q <= 1'b1;
            out_k_q     <= k_q;
            out_fin_q   <= emit_fin_q && (emit_cnt_q == 2'd1);
            emit_cnt_q  <= emit_cnt_q - 2'd1;
            if (emit_cnt_q == 2'd1) begin
              state_q <= StIdle;
            end
          end
        end
        default: begin
          if (!launch_div && !launch_sqrt) begin
            state_q <= StIdle;
          end
        end
      endcase
      // launch states hand over to the shared unit
      if (launch_div) begin
        state_q <= StDiv;
      end
      if (launch_sqrt) begin
        state_q <= StSqrt;
      end
    end
  end

endmodule

>>> hdl/pce_checker.sv
// Port-level checker for the path curvature estimator, bound to its top level.
// Depends on path_curvature_estimator_defines.svh.
`include "path_curvature_estimator_defines.svh"

module pce_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_end_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_curvature_i,
  input logic        out_final_i
);

  // hold a stalled result
  `PCE_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_curvature_i) && $stable(out_final_i), "stalled result changed")
  // a path end always leaves work to do
  `PCE_ASSERT_NXT(a_end_busy, in_valid_i && in_ready_i && in_end_i, !in_ready_i, "ready right after path end")
  // no result appears in the cycle after a request
  `PCE_ASSERT_NXT(a_min_latency, in_valid_i && in_ready_i, !$rose(out_valid_i), "result too early")

endmodule

bind path_curvature_estimator pce_checker u_pce_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (point_i.valid),
  .in_ready_i      (point_i.ready),
  .in_end_i        (point_i.path_end),
  .out_valid_i     (curv_o.valid),
  .out_ready_i     (curv_o.ready),
  .out_curvature_i (curv_o.curvature),
  .out_final_i     (curv_o.final_result)
);

>>> tb/pce_tb_if.sv
// Testbench copy point: the channel interfaces come from hdl/pce_if.sv.
// This file holds a small helper package of point and result types for the testbench.
// Depends on pce_pkg.
package pce_tb_pkg;
  typedef struct packed {
    logic signed [pce_pkg::CoordW-1:0] x;
    logic signed [pce_pkg::CoordW-1:0] y;
    logic                              last;
  } point_t;

  typedef struct packed {
    logic signed [pce_pkg::CurvW-1:0] curv;
    logic                             fin;
  } curv_res_t;
endpackage

>>> tb/pce_checker.sv
// Curvature checker: watches both channels, predicts curvature results
// per accepted path point and compares them in order.
// Depends on pce_pkg, pce_tb_pkg and the interfaces in hdl/pce_if.sv.
module pce_scoreboard (
  input  logic       clk_i,
  input  logic       rst_ni,
  pce_point_if       pt,
  pce_curv_if        cv,
  output int         fails_o,
  output int         pending_o
);

  logic signed [31:0]       win_x [2];
  logic signed [31:0]       win_y [2];
  int unsigned              held;
  pce_tb_pkg::curv_res_t    curv_q [$];

  function automatic logic [63:0] root66(logic [65:0] v);
    logic [67:0] rem, t;
    logic [63:0] r;
    r = 0;
    rem = 0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | 68'(v[2*i +: 2]);
      t = {r, 2'b01};
      if (rem >= t) begin
        rem = rem - t;
        r = {r[62:0], 1'b1};
      end else begin
        r = {r[62:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] chord_len(longint dx, longint dy);
    logic [63:0] mx, my;
    mx = dx < 0 ? -dx : dx;
    my = dy < 0 ? -dy : dy;
    return root66(66'(mx * mx) + 66'(my * my)) + 1;
  endfunction

  function automatic longint qdiv(longint n, logic [63:0] den);
    logic [63:0] q;
    logic [63:0] m;
    m = n < 0 ? -n : n;
    q = (m << 30) / den;
    return n < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [31:0] window_curvature(longint x0, longint y0,
      longint x1, longint y1, longint x2, longint y2);
    logic [63:0] ds1, ds2, s, cm, t, v2, sq, d, q;
    longint xp, yp, dux, duy, c;
    ds1 = chord_len(x1 - x0, y1 - y0);
    ds2 = chord_len(x2 - x1, y2 - y1);
    s = ds1 + ds2;
    xp = qdiv(x2 - x0, s);
    yp = qdiv(y2 - y0, s);
    dux = qdiv(x2 - x1, ds2) - qdiv(x1 - x0, ds1);
    duy = qdiv(y2 - y1, ds2) - qdiv(y1 - y0, ds1);
    c = xp * duy - yp * dux;
    cm = (c < 0 ? -c : c);
    cm = cm >> 30;
    t = (cm << 17) / s;
    v2 = (64'(xp * xp) + 64'(yp * yp)) >> 30;
    sq = root66(66'(v2) << 30);
    d = ((v2 * sq) >> 30) + 1;
    q = (t << 16) / d;
    if (c >= 0) begin
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return q[31:0];
    end
    if (q > 64'h8000_0000) q = 64'h8000_0000;
    return -q[31:0];
  endfunction

  function automatic pce_tb_pkg::curv_res_t mk(logic signed [31:0] k, logic f);
    pce_tb_pkg::curv_res_t r;
    r.curv = k;
    r.fin = f;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic signed [31:0] k;
    pce_tb_pkg::curv_res_t got, exp_r;
    int nf;
    nf = 0;
    if (!rst_ni) begin
      held <= 0;
      fails_o <= 0;
      pending_o <= 0;
      win_x[0] <= '0; win_x[1] <= '0;
      win_y[0] <= '0; win_y[1] <= '0;
    end else begin
      if (pt.valid && pt.ready) begin
        if (held < 2) begin
          if (pt.path_end) begin
            if (held == 1) curv_q.insert(curv_q.size(), mk('0, 1'b0));
            curv_q.insert(curv_q.size(), mk('0, 1'b1));
            held <= 0;
          end else begin
            held <= held + 1;
          end
        end else begin
          k = window_curvature(win_x[0], win_y[0], win_x[1], win_y[1],
                               pt.point_x, pt.point_y);
          if (held == 2) curv_q.insert(curv_q.size(), mk(k, 1'b0));
          curv_q.insert(curv_q.size(), mk(k, 1'b0));
          if (pt.path_end) begin
            curv_q.insert(curv_q.size(), mk(k, 1'b1));
            held <= 0;
          end else begin
            held <= 3;
          end
        end
        win_x[0] <= win_x[1]; win_x[1] <= pt.point_x;
        win_y[0] <= win_y[1]; win_y[1] <= pt.point_y;
      end
      if (cv.valid && cv.ready) begin
        got = mk(cv.curvature, cv.final_result);
        if (curv_q.size() == 0) begin
          $error("curvature: expected no result, got %0d", got.curv);
          nf++;
        end else begin
          exp_r = curv_q.pop_front();
          if (got.curv !== exp_r.curv) begin
            $error("curvature: expected %0d, got %0d", exp_r.curv, got.curv);
            nf++;
          end
          if (got.fin !== exp_r.fin) begin
            $error("final_result: expected %0d, got %0d", exp_r.fin, got.fin);
            nf++;
          end
        end
      end
      fails_o <= fails_o + nf;
      pending_o <= curv_q.size();
    end
  end

endmodule

>>> tb/testbench.sv
// Top of the path curvature estimator testbench: drives path points in
// bursts, stalls the result side and gives the verdict. Depends on the
// RTL in hdl/, pce_tb_pkg and pce_scoreboard in tb/pce_checker.sv.
module testbench;

  localparam int StallLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fails, pending;
  int   idle_cycles = 0;
  pce_tb_pkg::point_t pts [$];

  pce_point_if pt ();
  pce_curv_if  cv ();

  path_curvature_estimator dut (.clk_i, .rst_ni, .point_i(pt.sink), .curv_o(cv.source));
  pce_scoreboard chk (.clk_i, .rst_ni, .pt, .cv, .fails_o(fails), .pending_o(pending));

  always #10 clk_i = ~clk_i;

  // Result side stalls on its own pattern: quiet stretches and busy ones.
  int stall_mode = 0;
  always @(posedge clk_i) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: cv.ready <= 1'b1;
      1: cv.ready <= 1'($urandom_range(0, 1));
      2: cv.ready <= ($urandom_range(0, 7) == 0);
      default: cv.ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((pt.valid && pt.ready) || (cv.valid && cv.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 2000)) - 1000;
      2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    endcase
  endfunction

  task automatic add_pt(logic signed [31:0] x, logic signed [31:0] y, logic last);
    pce_tb_pkg::point_t p;
    p.x = x; p.y = y; p.last = last;
    pts.insert(pts.size(), p);
  endtask

  initial begin
    int len, mode, gap, burst;
    pce_tb_pkg::point_t p;
    pt.valid = 1'b0; pt.point_x = '0; pt.point_y = '0; pt.path_end = 1'b0;
    cv.ready = 1'b0;

    // One- and two-point paths, coincident points, extremes, sharp turn.
    add_pt(32'sd5, 32'sd7, 1'b1);
    add_pt(32'sh0001_0000, 32'sd0, 1'b0);
    add_pt(32'sh0002_0000, 32'sd0, 1'b1);
    add_pt(32'sd0, 32'sd0, 1'b0);
    add_pt(32'sd0, 32'sd0, 1'b0);
    add_pt(32'sd0, 32'sd0, 1'b1);
    add_pt(32'sh8000_0000, 32'sh8000_0000, 1'b0);
    add_pt(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
    add_pt(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    add_pt(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
    add_pt(32'sd0, 32'sd0, 1'b0);
    add_pt(32'sd1, 32'sd0, 1'b0);
    add_pt(32'sd0, 32'sd1, 1'b1);
    add_pt(32'sd0, 32'sd0, 1'b0);
    add_pt(32'sh0001_0000, 32'sd0, 1'b0);
    add_pt(32'sh0001_0000, 32'sh0001_0000, 1'b0);
    add_pt(32'sd0, 32'sh0001_0000, 1'b1);
    add_pt(32'sd0, 32'sd0, 1'b0);
    add_pt(32'sd0, 32'sd0, 1'b0);
    add_pt(32'sd3, -32'sd3, 1'b1);

    while (pts.size() < 200) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
      mode = $urandom_range(0, 3);
      for (int i = 0; i < len; i++)
        add_pt(rand_coord(mode), rand_coord(mode), i == len - 1);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    while (pts.size() > 0) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && pts.size() > 0) begin
        p = pts.pop_front();
        pt.valid <= 1'b1;
        pt.point_x <= p.x; pt.point_y <= p.y; pt.path_end <= p.last;
        do @(posedge clk_i); while (!pt.ready);
        burst--;
      end
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 300);
      if (gap > 0) begin
        pt.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    pt.valid <= 1'b0;
    @(posedge clk_i);

    while (pending > 0) @(posedge clk_i);
    repeat (1000) @(posedge clk_i);

    if (fails == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
